@@ sv/dpd_pkg.sv @@
`default_nettype none

package dpd_pkg;

    // Default payload buffer size in bytes
    localparam int DPD_BUF_BYTES = 512;

    // Framing characters
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ACK   = 8'h2B;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_TX      = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;

    // Report status codes
    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Command start offset when a sequence prefix is present
    localparam logic [1:0] CMD_START_SEQ = 2'd3;

    // Group of results caused by one received byte
    typedef enum logic [1:0] {
        BT_PAYLOAD,
        BT_OVERFLOW,
        BT_BAD,
        BT_GOOD
    } bundle_type_t;

    typedef struct packed {
        bundle_type_t btype;
        logic [7:0]   data;
        logic [8:0]   idx;
        logic [8:0]   len;
        logic         seq;
        logic [7:0]   seq_first;
        logic [7:0]   seq_second;
    } bundle_t;

    // Hex digit value; anything else gives all ones (-1 modulo 256)
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= 8'h61 && c <= 8'h66) begin
                v = c - 8'h57;
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                v = c - 8'h37;
            end else begin
                v = 8'hFF;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/dpd_core.sv @@
`default_nettype none

module dpd_core #(
    parameter int BUF_BYTES = dpd_pkg::DPD_BUF_BYTES
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    output logic                 bundle_load,
    output dpd_pkg::bundle_t     bundle,
    input  wire logic            bundle_ready
);
    import dpd_pkg::*;

    localparam int CW = $clog2(BUF_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(BUF_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_CSUM_HI,
        PH_CSUM_LO
    } phase_t;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    phase_t        phase_reg, phase_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    hi_reg, hi_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    seq1_reg, seq1_next;
    logic [7:0]    seq2_reg, seq2_next;
    logic          colon_reg, colon_next;

    logic          has_res;
    logic          fire;
    logic [7:0]    digit;
    logic [7:0]    rx_sum;
    logic [CW+8:0] cnt_ext;
    bundle_t       b;

    assign cnt_ext  = {9'd0, cnt_reg};
    assign digit    = hex_value(in_byte_reg);
    assign rx_sum   = hi_reg + digit;
    assign fire     = in_valid_reg && (!has_res || bundle_ready);
    assign in_ready = !in_valid_reg || fire;

    // Decode the held byte against the framing state
    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        cnt_next   = cnt_reg;
        seq1_next  = seq1_reg;
        seq2_next  = seq2_reg;
        colon_next = colon_reg;
        has_res    = 1'b0;
        b          = '0;
        b.btype    = BT_PAYLOAD;
        b.seq_first  = seq1_reg;
        b.seq_second = seq2_reg;
        case (phase_reg)
            PH_HUNT, PH_PAYLOAD: begin
                if (in_byte_reg == CH_START) begin
                    phase_next = PH_PAYLOAD;
                    sum_next   = '0;
                    hi_next    = '0;
                    cnt_next   = '0;
                    seq1_next  = '0;
                    seq2_next  = '0;
                    colon_next = 1'b0;
                end else if (phase_reg == PH_PAYLOAD) begin
                    if (in_byte_reg == CH_HASH) begin
                        if (cnt_reg == CNT_MAX) begin
                            has_res    = 1'b1;
                            b.btype    = BT_OVERFLOW;
                            phase_next = PH_HUNT;
                        end else begin
                            phase_next = PH_CSUM_HI;
                        end
                    end else begin
                        sum_next = sum_reg + in_byte_reg;
                        if (cnt_reg != CNT_MAX) begin
                            if (cnt_reg == CW'(0)) seq1_next = in_byte_reg;
                            if (cnt_reg == CW'(1)) seq2_next = in_byte_reg;
                            if (cnt_reg == CW'(2)) colon_next = (in_byte_reg == CH_COLON);
                            has_res  = 1'b1;
                            b.btype  = BT_PAYLOAD;
                            b.data   = in_byte_reg;
                            b.idx    = cnt_ext[8:0];
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end
                end
            end
            PH_CSUM_HI: begin
                hi_next    = {digit[3:0], 4'h0};
                phase_next = PH_CSUM_LO;
            end
            default: begin
                has_res = 1'b1;
                if (rx_sum == sum_reg) begin
                    b.btype = BT_GOOD;
                    b.len   = cnt_ext[8:0];
                    b.seq   = (cnt_reg >= CW'(3)) && colon_reg;
                end else begin
                    b.btype = BT_BAD;
                end
                phase_next = PH_HUNT;
            end
        endcase
    end

    assign bundle_load = fire && has_res;
    assign bundle      = b;

    // Hold the input byte and advance the framing state on each processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HUNT;
            sum_reg      <= '0;
            hi_reg       <= '0;
            cnt_reg      <= '0;
            seq1_reg     <= '0;
            seq2_reg     <= '0;
            colon_reg    <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (fire) begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                hi_reg    <= hi_next;
                cnt_reg   <= cnt_next;
                seq1_reg  <= seq1_next;
                seq2_reg  <= seq2_next;
                colon_reg <= colon_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

@@ sv/dpd_emit.sv @@
`default_nettype none

module dpd_emit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             bundle_load,
    input  wire dpd_pkg::bundle_t bundle,
    output logic                  bundle_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [1:0]            m_kind,
    output logic [7:0]            m_data_byte,
    output logic [8:0]            m_byte_index,
    output logic [1:0]            m_status,
    output logic [8:0]            m_payload_length,
    output logic [1:0]            m_command_start,
    output logic                  m_last
);
    import dpd_pkg::*;

    logic       valid_reg;
    bundle_t    bundle_reg;
    logic [1:0] step_reg;
    logic [1:0] step_last;

    // Index of the final result in the held group
    always_comb begin
        case (bundle_reg.btype)
            BT_GOOD: step_last = bundle_reg.seq ? 2'd3 : 2'd1;
            default: step_last = 2'd0;
        endcase
    end

    assign m_valid      = valid_reg;
    assign m_last       = (step_reg == step_last);
    assign bundle_ready = !valid_reg || (m_ready && m_last);

    // Select the result fields for the current step
    always_comb begin
        m_kind           = KIND_REPORT;
        m_data_byte      = '0;
        m_byte_index     = '0;
        m_status         = STATUS_GOOD;
        m_payload_length = '0;
        m_command_start  = '0;
        case (bundle_reg.btype)
            BT_PAYLOAD: begin
                m_kind       = KIND_PAYLOAD;
                m_data_byte  = bundle_reg.data;
                m_byte_index = bundle_reg.idx;
            end
            BT_OVERFLOW: begin
                m_status = STATUS_OVERFLOW;
            end
            BT_BAD: begin
                m_status = STATUS_BAD_SUM;
            end
            default: begin
                if (step_reg == step_last) begin
                    m_payload_length = bundle_reg.len;
                    m_command_start  = bundle_reg.seq ? CMD_START_SEQ : 2'd0;
                end else begin
                    m_kind = KIND_TX;
                    case (step_reg)
                        2'd1:    m_data_byte = bundle_reg.seq_first;
                        2'd2:    m_data_byte = bundle_reg.seq_second;
                        default: m_data_byte = CH_ACK;
                    endcase
                end
            end
        endcase
    end

    // Hold a group until its last result is transferred, then load the next
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end else if (bundle_ready) begin
            valid_reg <= bundle_load;
            step_reg  <= '0;
        end else if (m_ready) begin
            step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_ready && bundle_load) begin
            bundle_reg <= bundle;
        end
    end

endmodule

`default_nettype wire

@@ sv/debug_packet_deframer.sv @@
// Debug packet deframer: receive side of a debug host link ('$' payload '#' hh).
// Input channel s_valid/s_ready/s_rx_byte takes one received byte per transfer.
// Result channel m_valid/m_ready carries kind, data_byte, byte_index, status,
// payload_length, command_start and last; last marks the final result of a byte.
// Payload bytes come out with their index; a checksum match gives '+', the two
// sequence bytes when byte 2 is ':', and a good report; a mismatch or overflow
// gives one report.
// A byte is registered at its transfer and decoded in the next cycle; its results
// are then loaded into the result sequencer when it is free, which presents the first.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver takes it. The result sequencer sends one result per cycle while m_ready is
// high, so a closing checksum byte holds the decode stage until its last result goes.
// Reset (aresetn low, synchronous) returns the framer to hunting for '$' and
// empties the input and result registers.
// When the receiver stalls, the current result holds; bytes that cause no result
// keep flowing, the next byte that causes one waits in the input register, and
// then s_ready drops.
`default_nettype none

module debug_packet_deframer #(
    parameter int BUF_BYTES = dpd_pkg::DPD_BUF_BYTES
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_data_byte,
    output logic [8:0]      m_byte_index,
    output logic [1:0]      m_status,
    output logic [8:0]      m_payload_length,
    output logic [1:0]      m_command_start,
    output logic            m_last
);
    import dpd_pkg::*;

    logic    bundle_load;
    logic    bundle_ready;
    bundle_t bundle;

    dpd_core #(
        .BUF_BYTES (BUF_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_byte      (s_rx_byte),
        .bundle_load  (bundle_load),
        .bundle       (bundle),
        .bundle_ready (bundle_ready)
    );

    dpd_emit u_emit (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .bundle_load      (bundle_load),
        .bundle           (bundle),
        .bundle_ready     (bundle_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_byte_index     (m_byte_index),
        .m_status         (m_status),
        .m_payload_length (m_payload_length),
        .m_command_start  (m_command_start),
        .m_last           (m_last)
    );

    // A report always closes the group of its byte
    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_REPORT |-> m_last)
        else $error("report not marked last");

    // A payload byte is a single result with no status
    a_payload_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_PAYLOAD |-> m_last && m_status == STATUS_GOOD)
        else $error("payload result malformed");

    // Report-only fields stay clear outside reports
    a_report_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_REPORT |->
            m_payload_length == 9'd0 && m_command_start == 2'd0)
        else $error("report fields set on non-report result");

    // A sequence prefix is only reported on a good packet
    a_seq_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_start != 2'd0 |-> m_status == STATUS_GOOD)
        else $error("command start on bad report");

endmodule

`default_nettype wire

@@ bench/tb_debug_packet_deframer.sv @@
`timescale 1ns / 100ps

module tb_debug_packet_deframer;

    import dpd_pkg::*;

    localparam int PAYLOAD_CAP    = DPD_BUF_BYTES - 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 20;

    // Row types of the directed table
    localparam int PREDICT = -1;
    localparam int NO_RES  = 0;
    localparam int ONE_RES = 1;

    localparam logic [1:0] CMD_START_NONE = 2'd0;

    typedef enum logic [1:0] {
        FR_HUNT,
        FR_PAYLOAD,
        FR_SUM_HI,
        FR_SUM_LO
    } frame_phase_t;

    typedef enum int {
        SUM_GOOD,
        SUM_WRONG,
        SUM_JUNK
    } sum_style_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [8:0] idx;
        logic [1:0] status;
        logic [8:0] len;
        logic [1:0] cmd;
        logic       last;
    } deframe_result_t;

    typedef struct {
        logic [7:0]      rx;
        int              n_typed;
        deframe_result_t typed;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_data_byte;
    logic [8:0] m_byte_index;
    logic [1:0] m_status;
    logic [8:0] m_payload_length;
    logic [1:0] m_command_start;
    logic       m_last;

    // Predictor state
    frame_phase_t fr_phase  = FR_HUNT;
    logic [7:0]   sum_acc   = 8'h00;
    logic [7:0]   sum_hi_rx = 8'h00;
    logic [9:0]   pay_cnt   = 10'd0;
    logic [7:0]   seq_b0    = 8'h00;
    logic [7:0]   seq_b1    = 8'h00;
    logic         colon_hit = 1'b0;

    deframe_result_t byte_outputs[$];
    deframe_result_t pending_results[$];
    deframe_result_t want;
    dir_row_t        directed_rows[$];

    int  send_idle_pct = 30;
    int  recv_idle_pct = 85;
    int  live_items    = 0;
    int  error_count   = 0;
    int  stall_cycles  = 0;
    bit  hold_req      = 1'b0;

    debug_packet_deframer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_byte_index     (m_byte_index),
        .m_status         (m_status),
        .m_payload_length (m_payload_length),
        .m_command_start  (m_command_start),
        .m_last           (m_last)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic deframe_result_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                               input logic [8:0] idx, input logic [1:0] status,
                                               input logic [8:0] len, input logic [1:0] cmd,
                                               input logic last);
        deframe_result_t r;
        r.kind   = kind;
        r.data   = data;
        r.idx    = idx;
        r.status = status;
        r.len    = len;
        r.cmd    = cmd;
        r.last   = last;
        return r;
    endfunction

    // Hex digit value; anything that is not a digit counts as all ones
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 8'd10;
        if (c >= "A" && c <= "F") return c - "A" + 8'd10;
        return 8'hFF;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return 8'h30 + nib;
        return (upper ? "A" : "a") + nib - 8'd10;
    endfunction

    // Any byte that neither starts nor ends a payload
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_START || b == CH_HASH);
        return b;
    endfunction

    // Advance the framer model by one received byte, collect its results
    task automatic deframe_byte(input logic [7:0] c);
        logic [7:0] digit;
        logic [7:0] rx_sum;
        logic       seq;
        byte_outputs.delete();
        digit = digit_value(c);
        case (fr_phase)
            FR_HUNT, FR_PAYLOAD: begin
                if (c == CH_START) begin
                    fr_phase  = FR_PAYLOAD;
                    sum_acc   = 8'h00;
                    sum_hi_rx = 8'h00;
                    pay_cnt   = 10'd0;
                    seq_b0    = 8'h00;
                    seq_b1    = 8'h00;
                    colon_hit = 1'b0;
                end else if (fr_phase == FR_PAYLOAD) begin
                    if (c == CH_HASH) begin
                        if (pay_cnt >= PAYLOAD_CAP) begin
                            byte_outputs.push_back(mk_res(KIND_REPORT, 8'h00, 9'd0,
                                STATUS_OVERFLOW, 9'd0, CMD_START_NONE, 1'b0));
                            fr_phase = FR_HUNT;
                        end else begin
                            fr_phase = FR_SUM_HI;
                        end
                    end else begin
                        sum_acc = sum_acc + c;
                        // past the buffer the byte is summed and dropped
                        if (pay_cnt < PAYLOAD_CAP) begin
                            if (pay_cnt == 10'd0) seq_b0 = c;
                            if (pay_cnt == 10'd1) seq_b1 = c;
                            if (pay_cnt == 10'd2) colon_hit = (c == CH_COLON);
                            byte_outputs.push_back(mk_res(KIND_PAYLOAD, c, pay_cnt[8:0],
                                STATUS_GOOD, 9'd0, CMD_START_NONE, 1'b0));
                            pay_cnt = pay_cnt + 10'd1;
                        end
                    end
                end
            end
            FR_SUM_HI: begin
                sum_hi_rx = {digit[3:0], 4'h0};
                fr_phase  = FR_SUM_LO;
            end
            default: begin
                rx_sum = sum_hi_rx + digit;
                if (rx_sum == sum_acc) begin
                    // short payloads never carry a sequence prefix
                    seq = (pay_cnt >= 10'd3) && colon_hit;
                    byte_outputs.push_back(mk_res(KIND_TX, CH_ACK, 9'd0, STATUS_GOOD, 9'd0,
                        CMD_START_NONE, 1'b0));
                    if (seq) begin
                        byte_outputs.push_back(mk_res(KIND_TX, seq_b0, 9'd0, STATUS_GOOD,
                            9'd0, CMD_START_NONE, 1'b0));
                        byte_outputs.push_back(mk_res(KIND_TX, seq_b1, 9'd0, STATUS_GOOD,
                            9'd0, CMD_START_NONE, 1'b0));
                    end
                    byte_outputs.push_back(mk_res(KIND_REPORT, 8'h00, 9'd0, STATUS_GOOD,
                        pay_cnt[8:0], seq ? CMD_START_SEQ : CMD_START_NONE, 1'b0));
                end else begin
                    byte_outputs.push_back(mk_res(KIND_REPORT, 8'h00, 9'd0, STATUS_BAD_SUM,
                        9'd0, CMD_START_NONE, 1'b0));
                end
                fr_phase = FR_HUNT;
            end
        endcase
        if (byte_outputs.size() != 0) byte_outputs[byte_outputs.size() - 1].last = 1'b1;
    endtask

    // Offer one byte, wait for its transfer and queue what it should produce
    task automatic send_byte(input logic [7:0] rx, input int n_typed = PREDICT,
                             input deframe_result_t typed = '0);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        if (fr_phase != FR_HUNT || rx == CH_START) live_items++;
        deframe_byte(rx);
        if (n_typed == PREDICT) begin
            foreach (byte_outputs[i]) pending_results.push_back(byte_outputs[i]);
        end else if (n_typed == ONE_RES) begin
            pending_results.push_back(typed);
        end
        @(negedge aclk);
    endtask

    task automatic send_packet(input int len, input bit colon, input sum_style_t style);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        send_byte(CH_START);
        for (int i = 0; i < len; i++) begin
            b = (colon && i == 2) ? CH_COLON : payload_byte();
            sum = sum + b;
            send_byte(b);
        end
        send_byte(CH_HASH);
        // an overflowing payload takes no checksum
        if (len < PAYLOAD_CAP) begin
            if (style == SUM_JUNK) begin
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                if (style == SUM_WRONG) sum = sum ^ 8'($urandom_range(1, 255));
                send_byte(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
                send_byte(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic random_traffic(input int goal);
        int pick;
        int len;
        while (live_items < goal) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            if (pick < 60) begin
                send_packet(len, 1'($urandom_range(0, 1)), SUM_GOOD);
            end else if (pick < 72) begin
                send_packet(len, 1'($urandom_range(0, 1)), SUM_WRONG);
            end else if (pick < 80) begin
                send_packet(len, 1'b0, SUM_JUNK);
            end else if (pick < 92) begin
                // abandon a packet; the next start byte restarts it or lands in the checksum
                send_byte(CH_START);
                for (int i = 0; i < len; i++) send_byte(payload_byte());
                if ($urandom_range(0, 1)) begin
                    send_byte(CH_HASH);
                    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                end
            end else begin
                // line noise between packets
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stop offering and wait until every queued result has come out
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // Receiver: random back-pressure, with one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready  <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result mismatch, expected none, actual kind %0d data %0d",
                         $time, m_kind, m_data_byte);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, m_kind);
                check_field("data_byte", want.data, m_data_byte);
                check_field("byte_index", want.idx, m_byte_index);
                check_field("status", want.status, m_status);
                check_field("payload_length", want.len, m_payload_length);
                check_field("command_start", want.cmd, m_command_start);
                check_field("last", want.last, m_last);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;

        // Directed bytes: hunting, extremes, empty payload, bad digits,
        // start byte inside the checksum, sequence prefix, upper-case hex
        directed_rows.push_back('{"A", NO_RES, '0});
        directed_rows.push_back('{CH_HASH, NO_RES, '0});
        directed_rows.push_back('{CH_START, NO_RES, '0});
        directed_rows.push_back('{8'h00, ONE_RES, mk_res(KIND_PAYLOAD, 8'h00, 9'd0,
                                  STATUS_GOOD, 9'd0, CMD_START_NONE, 1'b1)});
        directed_rows.push_back('{8'hFF, ONE_RES, mk_res(KIND_PAYLOAD, 8'hFF, 9'd1,
                                  STATUS_GOOD, 9'd0, CMD_START_NONE, 1'b1)});
        directed_rows.push_back('{CH_START, NO_RES, '0});
        directed_rows.push_back('{CH_HASH, NO_RES, '0});
        directed_rows.push_back('{"0", NO_RES, '0});
        directed_rows.push_back('{"0", PREDICT, '0});
        directed_rows.push_back('{CH_START, NO_RES, '0});
        directed_rows.push_back('{CH_HASH, NO_RES, '0});
        directed_rows.push_back('{CH_START, NO_RES, '0});
        directed_rows.push_back('{"z", ONE_RES, mk_res(KIND_REPORT, 8'h00, 9'd0,
                                  STATUS_BAD_SUM, 9'd0, CMD_START_NONE, 1'b1)});
        directed_rows.push_back('{CH_START, NO_RES, '0});
        directed_rows.push_back('{"1", PREDICT, '0});
        directed_rows.push_back('{"2", PREDICT, '0});
        directed_rows.push_back('{CH_COLON, PREDICT, '0});
        directed_rows.push_back('{"g", PREDICT, '0});
        directed_rows.push_back('{CH_HASH, NO_RES, '0});
        directed_rows.push_back('{"0", NO_RES, '0});
        directed_rows.push_back('{"4", PREDICT, '0});
        directed_rows.push_back('{CH_START, NO_RES, '0});
        directed_rows.push_back('{"J", PREDICT, '0});
        directed_rows.push_back('{CH_HASH, NO_RES, '0});
        directed_rows.push_back('{"4", NO_RES, '0});
        directed_rows.push_back('{"A", PREDICT, '0});

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Slow sender, slower receiver
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].n_typed, directed_rows[i].typed);
        live_items = 0;
        random_traffic(85);
        drain();

        // Slow sender, eager receiver
        send_idle_pct = 85;
        recv_idle_pct = 30;
        random_traffic(170);
        drain();

        // No idling; one long receiver hold-off fills the block
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        random_traffic(250);
        // a payload past the buffer saturates, drops its tail and ends in overflow
        send_packet(PAYLOAD_CAP + 2, 1'b0, SUM_GOOD);
        random_traffic(live_items + 20);
        drain();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
